// File: hdl/fwlru_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwlru_pkg
// Constants, types and address helpers shared by the four-way tag lookup unit.
// ----------------------------------------------------------------------------
package fwlru_pkg;

   localparam int NUM_SETS        = 64;
   localparam int LINE_BYTES      = 16;
   localparam int WAYS            = 4;
   localparam int WAY_BITS        = 2;
   localparam int AGE_BITS        = 2;
   localparam int ADDR_BITS       = 32;
   localparam int ACCESS_BYTES    = 4;
   localparam int OFF_BITS        = $clog2(LINE_BYTES);
   localparam int IDX_BITS        = $clog2(NUM_SETS);
   localparam int TAG_BITS        = ADDR_BITS - OFF_BITS - IDX_BITS;
   localparam int SET_OUT_BITS    = 6;
   localparam int OFFSET_OUT_BITS = 4;

   localparam logic [AGE_BITS-1:0] AGE_NEWEST = 2'd3;
   localparam logic [AGE_BITS-1:0] AGE_OLDEST = 2'd0;

   typedef logic [ADDR_BITS-1:0] addr_type;
   typedef logic [IDX_BITS-1:0]  set_type;
   typedef logic [TAG_BITS-1:0]  tag_type;
   typedef logic [WAY_BITS-1:0]  way_type;
   typedef logic [AGE_BITS-1:0]  age_type;

   typedef struct packed {
      logic    valid;
      age_type age;
      tag_type tag;
   } way_entry_type;

   typedef way_entry_type [WAYS-1:0] row_type;

   localparam int ROW_BITS = $bits(row_type);

   typedef struct packed {
      logic    hit;
      way_type way;
      row_type row;
   } lookup_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK1,
      ST_LOOK2
   } state_type;

   // The index field can exceed the set count when it is not a power of two;
   // it is then below twice the count, so one subtraction wraps it.
   function automatic set_type set_of(input addr_type addr);
      logic [IDX_BITS:0] idx;
      idx = {1'b0, addr[OFF_BITS +: IDX_BITS]};
      if (idx >= (IDX_BITS+1)'(NUM_SETS)) begin
         idx = idx - (IDX_BITS+1)'(NUM_SETS);
      end
      return idx[IDX_BITS-1:0];
   endfunction

   function automatic tag_type tag_of(input addr_type addr);
      return addr[ADDR_BITS-1 -: TAG_BITS];
   endfunction

   function automatic logic [SET_OUT_BITS-1:0] set_out(input set_type s);
      addr_type wide;
      wide = ADDR_BITS'(s);
      return wide[SET_OUT_BITS-1:0];
   endfunction

   function automatic logic [OFFSET_OUT_BITS-1:0] offset_out(input addr_type addr);
      addr_type wide;
      wide = ADDR_BITS'(addr[OFF_BITS-1:0]);
      return wide[OFFSET_OUT_BITS-1:0];
   endfunction

endpackage : fwlru_pkg
`default_nettype wire

// File: hdl/fwlru_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwlru_if
// Valid/ready channels for access words and lookup result words.
// ----------------------------------------------------------------------------
interface fwlru_req_if
   import fwlru_pkg::*;
();
   logic     valid;
   logic     ready;
   addr_type byte_address;

   modport source (output valid, output byte_address, input ready);
   modport sink   (input valid, input byte_address, output ready);
endinterface : fwlru_req_if

interface fwlru_rsp_if
   import fwlru_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic                       all_hit;
   logic                       first_hit;
   logic [SET_OUT_BITS-1:0]    first_set;
   way_type                    first_way;
   logic [OFFSET_OUT_BITS-1:0] line_offset;
   logic                       spans_two;
   logic                       second_hit;
   logic [SET_OUT_BITS-1:0]    second_set;
   way_type                    second_way;

   modport source (output valid, output all_hit, output first_hit, output first_set,
                   output first_way, output line_offset, output spans_two,
                   output second_hit, output second_set, output second_way,
                   input ready);
   modport sink   (input valid, input all_hit, input first_hit, input first_set,
                   input first_way, input line_offset, input spans_two,
                   input second_hit, input second_set, input second_way,
                   output ready);
endinterface : fwlru_rsp_if
`default_nettype wire

// File: hdl/fwlru_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwlru_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. A read of the address being written returns the
// old contents.
// ----------------------------------------------------------------------------
module fwlru_ram #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = 16,
   localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  wr_en,
   input  wire logic [ADDR_W-1:0]     wr_addr,
   input  wire logic [DATA_WIDTH-1:0] wr_data,
   input  wire logic [ADDR_W-1:0]     rd_addr,
   output logic      [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : fwlru_ram
`default_nettype wire

// File: hdl/fwlru_way_update.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwlru_way_update
// Hit search, victim choice and age update for one set row.
// ----------------------------------------------------------------------------
module fwlru_way_update
   import fwlru_pkg::*;
(
   input  wire row_type    row_in,
   input  wire tag_type    tag,
   output lookup_type      result
);

   logic    hit;
   logic    found;
   way_type pick;
   age_type ref_age;
   row_type row_out;

   always_comb begin
      hit   = 1'b0;
      found = 1'b0;
      pick  = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (!found && row_in[w].valid && (row_in[w].tag == tag)) begin
            pick  = WAY_BITS'(w);
            found = 1'b1;
            hit   = 1'b1;
         end
      end
      for (int w = 0; w < WAYS; w++) begin
         if (!found && !row_in[w].valid) begin
            pick  = WAY_BITS'(w);
            found = 1'b1;
         end
      end
      for (int w = 0; w < WAYS; w++) begin
         if (!found && (row_in[w].age == AGE_OLDEST)) begin
            pick  = WAY_BITS'(w);
            found = 1'b1;
         end
      end
   end

   // The chosen way is valid after allocation; it never ages itself since
   // its own age is not above the reference.
   always_comb begin
      row_out = row_in;
      ref_age = row_in[pick].age;
      if (!hit) begin
         row_out[pick].tag   = tag;
         row_out[pick].valid = 1'b1;
      end
      for (int w = 0; w < WAYS; w++) begin
         if (row_out[w].valid && (row_in[w].age > ref_age)) begin
            row_out[w].age = row_in[w].age - 1'b1;
         end
      end
      row_out[pick].age = AGE_NEWEST;
   end

   assign result = '{hit: hit, way: pick, row: row_out};

endmodule : fwlru_way_update
`default_nettype wire

// File: hdl/four_way_lru_tag_lookup_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// four_way_lru_tag_lookup_unit
// Tag and age controller of a four-way set-associative cache.
// ----------------------------------------------------------------------------
// An access word is taken whenever the unit is idle and gives one result word.
// An access within one line is handled as accept and tag RAM read, then
// lookup and write-back; an access that crosses a line end adds its own
// read-modify-write of the tag RAM for the second line. The tag RAM holds
// one row of four ways per set and has one read port and one write port
// with registered read data. Per-set valid flags in flip-flops stand in for
// the reset of the valid bits and ages, so no clearing pass is needed after
// reset. A result word waits in an output register; the unit takes the next
// access meanwhile and holds its own result back only when the register is
// still full.
// ----------------------------------------------------------------------------
module four_way_lru_tag_lookup_unit
   import fwlru_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   fwlru_req_if.sink     req_bus,
   fwlru_rsp_if.source   rsp_bus
);

   state_type              state_ff, state_in;
   addr_type               addr_ff, addr_in;
   logic                   hit1_ff, hit1_in;
   way_type                way1_ff, way1_in;
   logic                   fwd_ff, fwd_in;
   row_type                fwd_row_ff, fwd_row_in;
   logic [NUM_SETS-1:0]    row_valid_ff, row_valid_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       all_hit_ff, all_hit_in;
   logic                       first_hit_ff, first_hit_in;
   logic [SET_OUT_BITS-1:0]    first_set_ff, first_set_in;
   way_type                    first_way_ff, first_way_in;
   logic [OFFSET_OUT_BITS-1:0] line_offset_ff, line_offset_in;
   logic                       spans_two_ff, spans_two_in;
   logic                       second_hit_ff, second_hit_in;
   logic [SET_OUT_BITS-1:0]    second_set_ff, second_set_in;
   way_type                    second_way_ff, second_way_in;

   addr_type          addr2;
   addr_type          cur_addr;
   set_type           cur_set;
   set_type           set2;
   logic              spans;
   logic              slot_free;
   logic              advance;
   logic              load_rsp;
   logic              ram_we;
   set_type           ram_rd_addr;
   logic [ROW_BITS-1:0] ram_rd_data;
   row_type           ram_row;
   row_type           row_eff;
   lookup_type        upd;

   assign addr2     = addr_ff + ADDR_BITS'(ACCESS_BYTES);
   assign set2      = set_of(addr2);
   assign cur_addr  = (state_ff == ST_LOOK2) ? addr2 : addr_ff;
   assign cur_set   = set_of(cur_addr);
   assign spans     = ({1'b0, addr_ff[OFF_BITS-1:0]} + (OFF_BITS+1)'(ACCESS_BYTES))
                      > (OFF_BITS+1)'(LINE_BYTES);
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign ram_row   = row_type'(ram_rd_data);

   // A set never written reads as all ways invalid with age zero; the row
   // written for the first line is forwarded when the second shares its set.
   always_comb begin
      row_eff = ram_row;
      if (fwd_ff) begin
         row_eff = fwd_row_ff;
      end else if (!row_valid_ff[cur_set]) begin
         for (int w = 0; w < WAYS; w++) begin
            row_eff[w].valid = 1'b0;
            row_eff[w].age   = AGE_OLDEST;
         end
      end
   end

   fwlru_ram #(
      .DATA_WIDTH (ROW_BITS),
      .DEPTH      (NUM_SETS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cur_set),
      .wr_data (ROW_BITS'(upd.row)),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   fwlru_way_update u_way_update (
      .row_in (row_eff),
      .tag    (tag_of(cur_addr)),
      .result (upd)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = ST_LOOK1;
            end
         end
         ST_LOOK1: begin
            if (spans) begin
               state_in = ST_LOOK2;
            end else if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_LOOK2: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_bus.ready = 1'b0;
      advance       = 1'b0;
      load_rsp      = 1'b0;
      ram_rd_addr   = cur_set;
      fwd_in        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            ram_rd_addr   = set_of(req_bus.byte_address);
         end
         ST_LOOK1: begin
            advance  = spans || slot_free;
            load_rsp = !spans && slot_free;
            if (spans) begin
               ram_rd_addr = set2;
               fwd_in      = (set2 == cur_set);
            end
         end
         ST_LOOK2: begin
            advance  = slot_free;
            load_rsp = slot_free;
         end
         default: begin
            advance = 1'b0;
         end
      endcase
   end

   assign ram_we     = advance;
   assign fwd_row_in = upd.row;

   always_comb begin
      addr_in      = addr_ff;
      hit1_in      = hit1_ff;
      way1_in      = way1_ff;
      row_valid_in = row_valid_ff;
      if (req_bus.valid && req_bus.ready) begin
         addr_in = req_bus.byte_address;
      end
      if ((state_ff == ST_LOOK1) && spans) begin
         hit1_in = upd.hit;
         way1_in = upd.way;
      end
      if (advance) begin
         row_valid_in[cur_set] = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      all_hit_in     = all_hit_ff;
      first_hit_in   = first_hit_ff;
      first_set_in   = first_set_ff;
      first_way_in   = first_way_ff;
      line_offset_in = line_offset_ff;
      spans_two_in   = spans_two_ff;
      second_hit_in  = second_hit_ff;
      second_set_in  = second_set_ff;
      second_way_in  = second_way_ff;
      if (load_rsp) begin
         rsp_valid_in   = 1'b1;
         first_set_in   = set_out(set_of(addr_ff));
         line_offset_in = offset_out(addr_ff);
         if (state_ff == ST_LOOK2) begin
            all_hit_in    = hit1_ff && upd.hit;
            first_hit_in  = hit1_ff;
            first_way_in  = way1_ff;
            spans_two_in  = 1'b1;
            second_hit_in = upd.hit;
            second_set_in = set_out(cur_set);
            second_way_in = upd.way;
         end else begin
            all_hit_in    = upd.hit;
            first_hit_in  = upd.hit;
            first_way_in  = upd.way;
            spans_two_in  = 1'b0;
            second_hit_in = 1'b0;
            second_set_in = '0;
            second_way_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fwd_ff       <= 1'b0;
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fwd_ff       <= fwd_in;
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff        <= addr_in;
      hit1_ff        <= hit1_in;
      way1_ff        <= way1_in;
      fwd_row_ff     <= fwd_row_in;
      all_hit_ff     <= all_hit_in;
      first_hit_ff   <= first_hit_in;
      first_set_ff   <= first_set_in;
      first_way_ff   <= first_way_in;
      line_offset_ff <= line_offset_in;
      spans_two_ff   <= spans_two_in;
      second_hit_ff  <= second_hit_in;
      second_set_ff  <= second_set_in;
      second_way_ff  <= second_way_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.all_hit     = all_hit_ff;
   assign rsp_bus.first_hit   = first_hit_ff;
   assign rsp_bus.first_set   = first_set_ff;
   assign rsp_bus.first_way   = first_way_ff;
   assign rsp_bus.line_offset = line_offset_ff;
   assign rsp_bus.spans_two   = spans_two_ff;
   assign rsp_bus.second_hit  = second_hit_ff;
   assign rsp_bus.second_set  = second_set_ff;
   assign rsp_bus.second_way  = second_way_ff;

endmodule : four_way_lru_tag_lookup_unit
`default_nettype wire

// File: hdl/fwlru_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwlru_checker
// Port-level checks of the tag lookup unit, bound to its top level.
// ----------------------------------------------------------------------------
module fwlru_checker
   import fwlru_pkg::*;
(
   input wire logic                    clock,
   input wire logic                    reset,
   input wire logic                    req_valid,
   input wire logic                    req_ready,
   input wire logic                    rsp_valid,
   input wire logic                    rsp_ready,
   input wire logic                    all_hit,
   input wire logic                    first_hit,
   input wire logic                    spans_two,
   input wire logic                    second_hit,
   input wire logic [SET_OUT_BITS-1:0] second_set,
   input wire way_type                 second_way
);

   // A result word waiting for the sink stays offered.
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word withdrawn before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(all_hit) && $stable(first_hit)
         && $stable(spans_two) && $stable(second_hit))
      else $error("result word changed while stalled");

   // Only one access is in flight: the unit is busy right after taking one.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("access taken while the previous one is still in the lookup");

   a_all_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> all_hit == (first_hit && (!spans_two || second_hit)))
      else $error("all_hit disagrees with the per-line hits");

   a_single_line: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !spans_two |-> !second_hit && (second_set == '0)
         && (second_way == '0))
      else $error("second-line fields set for an access within one line");

endmodule : fwlru_checker

bind four_way_lru_tag_lookup_unit fwlru_checker u_fwlru_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .all_hit    (rsp_bus.all_hit),
   .first_hit  (rsp_bus.first_hit),
   .spans_two  (rsp_bus.spans_two),
   .second_hit (rsp_bus.second_hit),
   .second_set (rsp_bus.second_set),
   .second_way (rsp_bus.second_way)
);
`default_nettype wire
